// ===== rtl/four_level_page_table_walker_unit_macros.svh =====
// Assertion macros for the page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table walker check failed");
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table walker check failed");
`else
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ptw_pkg.sv =====
package ptw_pkg;

  localparam int unsigned TABLE_FRAMES_DEF = 64;
  localparam int unsigned IDX_W = 9;

  // Request kinds.
  localparam logic [1:0] KIND_TRANSLATE = 2'd0;
  localparam logic [1:0] KIND_MAP       = 2'd1;
  localparam logic [1:0] KIND_UNMAP     = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOMEM     = 3'd2;
  localparam logic [2:0] ST_ALREADY   = 3'd3;
  localparam logic [2:0] ST_NOTMAPPED = 3'd4;

  // Entry bit positions.
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_USER    = 2;

  // Table index of a 48-bit virtual address at a walk level (0 is the root).
  function automatic logic [IDX_W-1:0] lvl_index(input logic [47:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/four_level_page_table_walker_unit.sv =====
// Four-level page table walker with its table tree in one internal RAM of
// TABLE_FRAMES frames of 512 64-bit entries (frame 0 is the root). Requests
// are translate, map and unmap; each gives one result. A request walks each
// level as a RAM read, then evaluate and write back. A walk leaves its done
// state and puts its result on the output once the output slot is free, and
// the input becomes ready in the same cycle that the result appears. A walk
// that stops at a missing level skips the read and evaluation of the levels
// below it. A refused address goes straight to the done state with no walk.
// Every table that a map allocates is cleared first by a sweep of its 512
// entries through the single RAM write port. After reset the root frame is
// swept the same way, and the input is not ready until that sweep ends. One
// result may wait at the output while the next request is accepted and walked.
module four_level_page_table_walker_unit
  import ptw_pkg::*;
#(
  parameter int unsigned TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] vaddr_i,
  input  logic [51:0] paddr_i,
  input  logic [11:0] flags_i,
  input  logic        no_execute_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [51:0] phys_result_o,
  output logic        mapped_o,
  output logic [6:0]  tables_in_use_o
);

`include "four_level_page_table_walker_unit_macros.svh"

  localparam int unsigned FW    = $clog2(TABLE_FRAMES);
  localparam int unsigned CW    = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned AW    = FW + IDX_W;
  localparam int unsigned DEPTH = TABLE_FRAMES * 512;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             walk_q, walk_d;
  logic [FW-1:0]    fr_q, fr_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic [CW-1:0]    nf_q, nf_d;

  logic [1:0]  kind_q, kind_d;
  logic [47:0] va_q, va_d;
  logic [39:0] pa_q, pa_d;
  logic [11:0] flg_q, flg_d;
  logic        nx_q, nx_d;

  logic [2:0]  res_status_q, res_status_d;
  logic [51:0] res_phys_q, res_phys_d;
  logic        res_mapped_q, res_mapped_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [51:0] phys_q;
  logic        mapped_q;
  logic [6:0]  tiu_q;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0] mem_wdata;

  logic [IDX_W-1:0] cur_idx;
  logic             child_ok;
  logic             alloc;
  logic             canon_in;
  logic             slot_free;
  logic [CW+6:0]    nf_ext;

  assign cur_idx   = lvl_index(va_q, lvl_q);
  assign child_ok  = rdata_q[BIT_PRESENT] && (rdata_q[51:12] < 40'(TABLE_FRAMES));
  assign canon_in  = (vaddr_i[63:47] == '0) || (vaddr_i[63:47] == '1);
  assign slot_free = !out_valid_q || out_ready_i;
  assign alloc     = (state_q == S_EVAL) && (kind_q == KIND_MAP) && (lvl_q != 2'd3)
                     && !child_ok && (nf_q != CW'(TABLE_FRAMES));
  assign nf_ext    = {7'd0, nf_q};

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    fr_d         = fr_q;
    lvl_d        = lvl_q;
    clr_idx_d    = clr_idx_q;
    nf_d         = nf_q;
    kind_d       = kind_q;
    va_d         = va_q;
    pa_d         = pa_q;
    flg_d        = flg_q;
    nx_d         = nx_q;
    res_status_d = res_status_q;
    res_phys_d   = res_phys_q;
    res_mapped_d = res_mapped_q;
    mem_we       = 1'b0;
    mem_waddr    = {fr_q, cur_idx};
    mem_wdata    = '0;
    mem_raddr    = {fr_q, cur_idx};
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {fr_q, clr_idx_q};
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == '1) begin
          state_d = walk_q ? S_RD : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d       = kind_i;
          va_d         = vaddr_i[47:0];
          pa_d         = paddr_i[51:12];
          flg_d        = flags_i;
          nx_d         = no_execute_i;
          fr_d         = '0;
          lvl_d        = 2'd0;
          res_phys_d   = '0;
          res_mapped_d = 1'b0;
          res_status_d = ST_INVALID;
          state_d      = S_DONE;
          case (kind_i)
            KIND_TRANSLATE: begin
              if (canon_in) begin
                state_d = S_RD;
                walk_d  = 1'b1;
              end
            end
            KIND_MAP: begin
              if (canon_in && vaddr_i[11:0] == '0 && paddr_i[11:0] == '0) begin
                state_d = S_RD;
                walk_d  = 1'b1;
              end
            end
            KIND_UNMAP: begin
              if (canon_in && vaddr_i[11:0] == '0) begin
                state_d = S_RD;
                walk_d  = 1'b1;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (lvl_q != 2'd3) begin
          if (child_ok) begin
            // Map raises the user bit on present intermediates along the path.
            if (kind_q == KIND_MAP && flg_q[BIT_USER]) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q | 64'(1 << BIT_USER);
            end
            fr_d    = rdata_q[12 +: FW];
            lvl_d   = lvl_q + 2'd1;
            state_d = S_RD;
          end else if (kind_q != KIND_MAP) begin
            res_status_d = ST_NOTMAPPED;
            state_d      = S_DONE;
          end else if (!alloc) begin
            res_status_d = ST_NOMEM;
            state_d      = S_DONE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {12'd0, 40'(nf_q), 9'd0, flg_q[BIT_USER], 2'b11};
            nf_d      = nf_q + 1'b1;
            fr_d      = nf_q[FW-1:0];
            lvl_d     = lvl_q + 2'd1;
            clr_idx_d = '0;
            state_d   = S_CLEAR;
          end
        end else begin
          state_d = S_DONE;
          case (kind_q)
            KIND_MAP: begin
              if (rdata_q[BIT_PRESENT]) begin
                res_status_d = ST_ALREADY;
              end else begin
                mem_we       = 1'b1;
                mem_wdata    = {nx_q, 11'd0, pa_q, flg_q | 12'h001};
                res_status_d = ST_OK;
              end
            end
            KIND_UNMAP: begin
              if (rdata_q[BIT_PRESENT]) begin
                mem_we       = 1'b1;
                res_status_d = ST_OK;
              end else begin
                res_status_d = ST_NOTMAPPED;
              end
            end
            default: begin
              if (rdata_q[BIT_PRESENT]) begin
                res_status_d = ST_OK;
                res_phys_d   = {rdata_q[51:12], va_q[11:0]};
                res_mapped_d = 1'b1;
              end else begin
                res_status_d = ST_NOTMAPPED;
              end
            end
          endcase
        end
      end
      S_DONE: begin
        if (slot_free) begin
          walk_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      walk_q    <= 1'b0;
      fr_q      <= '0;
      lvl_q     <= '0;
      clr_idx_q <= '0;
      nf_q      <= CW'(1);
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      fr_q      <= fr_d;
      lvl_q     <= lvl_d;
      clr_idx_q <= clr_idx_d;
      nf_q      <= nf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    va_q         <= va_d;
    pa_q         <= pa_d;
    flg_q        <= flg_d;
    nx_q         <= nx_d;
    res_status_q <= res_status_d;
    res_phys_q   <= res_phys_d;
    res_mapped_q <= res_mapped_d;
  end

  // Table RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && slot_free) begin
      status_q <= res_status_q;
      phys_q   <= res_phys_q;
      mapped_q <= res_mapped_q;
      tiu_q    <= nf_ext[6:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign phys_result_o   = phys_q;
  assign mapped_o        = mapped_q;
  assign tables_in_use_o = tiu_q;

  `PTW_ASSERT_IMP(a_nf_range, clk_i, rst_ni, 1'b1, nf_q <= CW'(TABLE_FRAMES))
  `PTW_ASSERT_NEXT(a_alloc_step, clk_i, rst_ni, alloc, nf_q == $past(nf_q) + 1'b1)
  `PTW_ASSERT_NEXT(a_nf_hold, clk_i, rst_ni, !alloc, $stable(nf_q))
  `PTW_ASSERT_IMP(a_mapped_ok, clk_i, rst_ni, out_valid_o && mapped_o, status_o == ST_OK)

endmodule

// ===== tb/sv/four_level_page_table_walker_unit_tb.sv =====
`timescale 1ns / 1ps

module four_level_page_table_walker_unit_tb;
  import ptw_pkg::*;

  localparam int unsigned FRAMES = TABLE_FRAMES_DEF;
  localparam int unsigned ENTRIES = 512;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int unsigned BIT_WRITABLE = 1;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned REGIONS = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT_RESULT = 320;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] va;
    logic [51:0] pa;
    logic [11:0] flags;
    logic        nx;
  } walk_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] phys;
    logic        mapped;
    logic [6:0]  tables;
  } walk_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [63:0] vaddr = '0;
  logic [51:0] paddr = '0;
  logic [11:0] flags = '0;
  logic        no_execute = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [51:0] phys_result;
  logic        mapped;
  logic [6:0]  tables_in_use;

  walk_req_t   request_q[$];
  walk_rsp_t   expected_walks[$];
  int unsigned accepted_cnt = 0;
  int unsigned results_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  // Mirror of the block's table tree and its frame allocator.
  logic [63:0] table_mirror [FRAMES*ENTRIES];
  int unsigned frames_taken;

  four_level_page_table_walker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .vaddr_i        (vaddr),
    .paddr_i        (paddr),
    .flags_i        (flags),
    .no_execute_i   (no_execute),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .phys_result_o  (phys_result),
    .mapped_o       (mapped),
    .tables_in_use_o(tables_in_use)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned entry_slot(int unsigned frame, logic [63:0] va, int lvl);
    logic [8:0] idx;
    idx = va[47 - 9*lvl -: 9];
    return frame * ENTRIES + idx;
  endfunction

  function automatic int child_of(logic [63:0] entry);
    if (!entry[BIT_PRESENT] || entry[51:12] >= FRAMES) return -1;
    return int'(entry[51:12]);
  endfunction

  function automatic bit is_canonical(logic [63:0] va);
    return (va[63:47] == '0) || (va[63:47] == '1);
  endfunction

  // Read-only descent to the last-level table; -1 when a level is missing.
  function automatic int leaf_table(logic [63:0] va);
    int fr;
    fr = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      fr = child_of(table_mirror[entry_slot(fr, va, lvl)]);
      if (fr < 0) return -1;
    end
    return fr;
  endfunction

  function automatic logic [2:0] install_page(walk_req_t r);
    int fr;
    int child;
    int unsigned nf;
    int unsigned pos;
    fr = 0;
    if (r.va[11:0] != '0 || r.pa[11:0] != '0 || !is_canonical(r.va)) return ST_INVALID;
    for (int lvl = 0; lvl < 3; lvl++) begin
      pos = entry_slot(fr, r.va, lvl);
      child = child_of(table_mirror[pos]);
      if (child >= 0) begin
        if (r.flags[BIT_USER]) table_mirror[pos][BIT_USER] = 1'b1;
        fr = child;
      end else begin
        // Tables built earlier in this request stay when the frames run out.
        if (frames_taken >= FRAMES) return ST_NOMEM;
        nf = frames_taken;
        frames_taken++;
        for (int k = 0; k < ENTRIES; k++) table_mirror[nf*ENTRIES + k] = '0;
        table_mirror[pos] = '0;
        table_mirror[pos][51:12] = 40'(nf);
        table_mirror[pos][BIT_PRESENT] = 1'b1;
        table_mirror[pos][BIT_WRITABLE] = 1'b1;
        table_mirror[pos][BIT_USER] = r.flags[BIT_USER];
        fr = nf;
      end
    end
    pos = entry_slot(fr, r.va, 3);
    if (table_mirror[pos][BIT_PRESENT]) return ST_ALREADY;
    table_mirror[pos] = {r.nx, 11'b0, r.pa[51:12], r.flags};
    table_mirror[pos][BIT_PRESENT] = 1'b1;
    return ST_OK;
  endfunction

  function automatic logic [2:0] remove_page(logic [63:0] va);
    int fr;
    int unsigned pos;
    if (va[11:0] != '0 || !is_canonical(va)) return ST_INVALID;
    fr = leaf_table(va);
    if (fr < 0) return ST_NOTMAPPED;
    pos = entry_slot(fr, va, 3);
    if (!table_mirror[pos][BIT_PRESENT]) return ST_NOTMAPPED;
    table_mirror[pos] = '0;
    return ST_OK;
  endfunction

  function automatic walk_rsp_t walk_result_of(walk_req_t r);
    walk_rsp_t rsp;
    int fr;
    logic [63:0] leaf;
    rsp = '0;
    rsp.status = ST_INVALID;
    case (r.kind)
      KIND_TRANSLATE: begin
        if (is_canonical(r.va)) begin
          rsp.status = ST_NOTMAPPED;
          fr = leaf_table(r.va);
          if (fr >= 0) begin
            leaf = table_mirror[entry_slot(fr, r.va, 3)];
            if (leaf[BIT_PRESENT]) begin
              rsp.status = ST_OK;
              rsp.phys = {leaf[51:12], r.va[11:0]};
              rsp.mapped = 1'b1;
            end
          end
        end
      end
      KIND_MAP: rsp.status = install_page(r);
      KIND_UNMAP: rsp.status = remove_page(r.va);
      default: ;
    endcase
    rsp.tables = frames_taken[6:0];
    return rsp;
  endfunction

  function automatic logic [63:0] region_addr(logic [8:0] i4, logic [8:0] i3, logic [8:0] i2,
                                              logic [8:0] i1);
    return {{16{i4[8]}}, i4, i3, i2, i1, 12'h000};
  endfunction

  task automatic queue_request(logic [1:0] k, logic [63:0] va, logic [51:0] pa,
                               logic [11:0] fl, logic nx);
    walk_req_t r;
    r.kind = k;
    r.va = va;
    r.pa = pa;
    r.flags = fl;
    r.nx = nx;
    request_q.push_back(r);
  endtask

  // Sender: a new request is offered only once the previous one has transferred.
  always @(posedge clk_i) begin : sender
    walk_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_walks.push_back(walk_result_of({kind, vaddr, paddr, flags,
                                                 no_execute}));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 &&
            ((accepted_cnt >= 150 && accepted_cnt < 260) || $urandom_range(99) >= 8)) begin
          nxt = request_q.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.kind;
          vaddr <= nxt.va;
          paddr <= nxt.pa;
          flags <= nxt.flags;
          no_execute <= nxt.nx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    walk_rsp_t want;
    logic ready_nxt;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_walks.size() == 0) begin
          $display("%0t: unexpected result transfer, status %0d phys %h", $time, status,
                   phys_result);
          errors++;
        end else begin
          want = expected_walks.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (phys_result !== want.phys) begin
            $display("%0t: phys_result expected %h actual %h", $time, want.phys, phys_result);
            errors++;
          end
          if (mapped !== want.mapped) begin
            $display("%0t: mapped expected %0d actual %0d", $time, want.mapped, mapped);
            errors++;
          end
          if (tables_in_use !== want.tables) begin
            $display("%0t: tables_in_use expected %0d actual %0d", $time, want.tables,
                     tables_in_use);
            errors++;
          end
        end
        results_cnt++;
      end
      // One long hold-off lets the block fill up and back-pressure its input.
      if (hold_left != 0) begin
        ready_nxt = 1'b0;
        hold_left--;
      end else if (!hold_done && results_cnt == HOLD_AT_RESULT) begin
        ready_nxt = 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        ready_nxt = (results_cnt >= 150 && results_cnt < 260) || $urandom_range(99) >= 8;
      end
      out_ready <= ready_nxt;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] region_base [REGIONS];
    logic [8:0]  top_set [4];
    logic [63:0] va;
    logic [63:0] a_va;
    logic [51:0] pa;
    logic [8:0]  leaf;
    int unsigned pick;

    for (int k = 0; k < FRAMES*ENTRIES; k++) table_mirror[k] = '0;
    frames_taken = 1;

    a_va = region_addr(9'd0, 9'd0, 9'd0, 9'd1);
    queue_request(KIND_TRANSLATE, 64'h0, '0, '0, 1'b0);
    queue_request(KIND_UNMAP, 64'h0, '0, '0, 1'b0);
    queue_request(KIND_MAP, a_va, 52'hF_FFFF_FFFF_F000, 12'h003, 1'b1);
    queue_request(KIND_TRANSLATE, a_va | 64'hFFF, '0, '0, 1'b0);
    queue_request(KIND_MAP, a_va, 52'h1000, 12'h001, 1'b0);
    queue_request(KIND_MAP, a_va + 64'h800, 52'h2000, 12'h001, 1'b0);
    queue_request(KIND_MAP, a_va + 64'h1000, 52'h123, 12'h001, 1'b0);
    queue_request(KIND_MAP, 64'hFFFF_FFFF_FFFF_F000, '0, 12'hFFF, 1'b0);
    queue_request(KIND_TRANSLATE, 64'hFFFF_FFFF_FFFF_FABC, '0, '0, 1'b0);
    queue_request(KIND_MAP, 64'h0000_8000_0000_0000, 52'h5000, 12'h003, 1'b0);
    queue_request(KIND_TRANSLATE, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
    queue_request(KIND_UNMAP, 64'hFFFF_0000_0000_0000, '0, '0, 1'b0);
    queue_request(KIND_UNMAP, a_va + 64'h4, '0, '0, 1'b0);
    // Shares the two upper levels with the first mapping, so those become user.
    queue_request(KIND_MAP, region_addr(9'd0, 9'd0, 9'd1, 9'd0), 52'h7000, 12'h007, 1'b1);
    queue_request(KIND_RESERVED, a_va, 52'h8000, 12'h003, 1'b1);
    queue_request(KIND_UNMAP, a_va, '0, '0, 1'b0);
    queue_request(KIND_UNMAP, a_va, '0, '0, 1'b0);
    queue_request(KIND_TRANSLATE, a_va, '0, '0, 1'b0);
    queue_request(KIND_MAP, a_va, '0, 12'h000, 1'b0);
    queue_request(KIND_TRANSLATE, a_va | 64'h555, '0, '0, 1'b0);
    queue_request(KIND_TRANSLATE, 64'h0000_7FFF_FFFF_FFFF, '0, '0, 1'b0);
    queue_request(KIND_MAP, 64'h0000_7FFF_FFFF_F000, 52'hA_BCDE_F012_3000, 12'h800, 1'b1);
    queue_request(KIND_TRANSLATE, 64'h0000_7FFF_FFFF_F000, '0, '0, 1'b0);

    // A few shared upper indexes, so that regions both reuse tables and use up
    // the frame store.
    top_set[0] = 9'd0;
    top_set[1] = 9'd511;
    top_set[2] = 9'($urandom);
    top_set[3] = 9'($urandom);
    for (int k = 0; k < REGIONS; k++)
      region_base[k] = region_addr(top_set[$urandom_range(3)], 9'($urandom_range(3)),
                                   9'($urandom), 9'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 12) begin
        queue_request(2'($urandom_range(3)), {$urandom, $urandom}, 52'({$urandom, $urandom}),
                      12'($urandom), 1'($urandom));
      end else begin
        leaf = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(3));
        va = region_base[$urandom_range(REGIONS - 1)];
        va[20:12] = leaf;
        pa = 52'({$urandom, $urandom});
        pa[11:0] = ($urandom_range(19) == 0) ? 12'($urandom) : 12'h000;
        pick = $urandom_range(99);
        if (pick < 40) begin
          va[11:0] = 12'($urandom);
          queue_request(KIND_TRANSLATE, va, pa, 12'($urandom), 1'($urandom));
        end else if (pick < 75) begin
          queue_request(KIND_MAP, va, pa, 12'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(19) == 0) va[11:0] = 12'($urandom_range(4095, 1));
          queue_request(KIND_UNMAP, va, pa, 12'($urandom), 1'($urandom));
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_walks.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptw_pkg.sv
rtl/four_level_page_table_walker_unit.sv
tb/sv/four_level_page_table_walker_unit_tb.sv
